>>> design/flash_erase_program_planner_macros.svh
// Assertion macros shared by the flash erase and program planner.
// Included by the top level; depends on nothing else.
`ifndef FLASH_ERASE_PROGRAM_PLANNER_MACROS_SVH
`define FLASH_ERASE_PROGRAM_PLANNER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every clock edge outside reset.
`define FEPP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every clock edge outside reset.
`define FEPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FEPP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define FEPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> design/fepp_pkg.sv
// Types and constants of the flash erase and program planner.
// Used by fepp_step and flash_erase_program_planner; depends on nothing.
package fepp_pkg;

    localparam int unsigned FLASH_BYTES_DEFAULT = 8388608;
    localparam int unsigned PAGE_BYTES_DEFAULT  = 256;

    localparam int unsigned ADDR_W   = 23;
    localparam int unsigned COUNT_W  = 24;
    localparam int unsigned LEN_W    = 17;
    // Wide enough to hold the flash size itself (up to 16 MB).
    localparam int unsigned CUR_W    = 25;
    localparam int unsigned LIMIT_W  = 24;

    localparam logic [CUR_W-1:0]   SECTOR_SPAN = 25'h0_1000;
    localparam logic [CUR_W-1:0]   BLOCK_SPAN  = 25'h1_0000;
    localparam logic [CUR_W-1:0]   BLOCK_TAIL  = BLOCK_SPAN - SECTOR_SPAN;
    localparam logic [LIMIT_W-1:0] SECTOR_BASE = 24'hFF_F000;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE         = 3'd0,
        OP_ERASE_64K    = 3'd1,
        OP_ERASE_4K     = 3'd2,
        OP_PAGE_PROGRAM = 3'd3,
        OP_ACCEPTED     = 3'd4
    } op_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ERASE   = 2'd1,
        PH_PROGRAM = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [CUR_W-1:0]     erase_cursor;
        logic [LIMIT_W-1:0]   erase_limit;
        logic [COUNT_W-1:0]   program_cursor;
        logic [COUNT_W-1:0]   bytes_left;
    } plan_state_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [ADDR_W-1:0]    address;
        logic [LEN_W-1:0]     length;
        logic                 error;
        logic                 last;
    } op_result_t;

endpackage

>>> design/flash_erase_program_planner.sv
// Top level of the flash erase and program planner: input stage, planner state,
// result stage. Depends on fepp_pkg, fepp_step and flash_erase_program_planner_macros.svh.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | command, start_address, byte_count
//   m_      | out       | m_valid / m_ready  | op_kind, op_address, op_length,
//           |           |                    | request_error, last_op
//
// One item is taken per cycle unless the result stage stalls; each item gives exactly one
// result item via both stages; planner state and result are registered in the same cycle.
// Reset (aresetn low at a clock edge) empties both stages and puts the planner idle.
// A stalled result holds the result stage; one more item then waits in the input
// stage, and s_ready falls only when both stages are full.
`include "flash_erase_program_planner_macros.svh"

module flash_erase_program_planner
    import fepp_pkg::*;
#(
    parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEFAULT,
    parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [ADDR_W-1:0]  s_start_address,
    input  logic [COUNT_W-1:0] s_byte_count,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_op_kind,
    output logic [ADDR_W-1:0]  m_op_address,
    output logic [LEN_W-1:0]   m_op_length,
    output logic               m_request_error,
    output logic               m_last_op
);

    // Input stage: the accepted item, held until the planner can act on it.
    logic               in_vld_reg;
    logic               cmd_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COUNT_W-1:0] count_reg;

    // Planner state, advanced once per planned item.
    plan_state_t        state_reg;
    plan_state_t        state_next;

    // Result stage.
    logic               out_vld_reg;
    op_result_t         res_reg;
    op_result_t         res_next;

    logic               plan_fire;

    // The planner runs whenever an item waits and the result stage frees up.
    assign plan_fire = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || plan_fire;

    fepp_step #(
        .FLASH_BYTES (FLASH_BYTES),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_step (
        .in_command       (cmd_reg),
        .in_start_address (addr_reg),
        .in_byte_count    (count_reg),
        .cur              (state_reg),
        .nxt              (state_next),
        .res              (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '{phase: PH_IDLE, erase_cursor: '0, erase_limit: '0,
                             program_cursor: '0, bytes_left: '0};
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (plan_fire) begin
                in_vld_reg <= 1'b0;
            end

            if (plan_fire) begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags above guard them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_command;
            addr_reg  <= s_start_address;
            count_reg <= s_byte_count;
        end
        if (plan_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_op_kind       = res_reg.kind;
    assign m_op_address    = res_reg.address;
    assign m_op_length     = res_reg.length;
    assign m_request_error = res_reg.error;
    assign m_last_op       = res_reg.last;

    // Only a page program may close a request.
    `FEPP_ASSERT_NOW(a_last_is_program, aclk, aresetn, m_valid && m_last_op, m_op_kind == OP_PAGE_PROGRAM, "last flag on a result that is not a page program")

    // A rejected start carries no operation.
    `FEPP_ASSERT_NOW(a_error_is_empty, aclk, aresetn, m_valid && m_request_error, m_op_kind == OP_NONE && m_op_length == '0, "rejected start carries an operation")

    // A block erase always starts on a 64 KB boundary.
    `FEPP_ASSERT_NOW(a_block_aligned, aclk, aresetn, m_valid && m_op_kind == OP_ERASE_64K, m_op_address[15:0] == 16'd0, "block erase off a 64 KB boundary")

    // A planned item always lands in the result stage.
    `FEPP_ASSERT_NEXT(a_plan_lands, aclk, aresetn, plan_fire, out_vld_reg, "planned item did not reach the result stage")

endmodule

>>> design/fepp_step.sv
// Combinational planning step: one item against the current planner state.
// Depends on fepp_pkg.
module fepp_step
    import fepp_pkg::*;
#(
    parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEFAULT,
    parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEFAULT
) (
    input  logic               in_command,
    input  logic [ADDR_W-1:0]  in_start_address,
    input  logic [COUNT_W-1:0] in_byte_count,
    input  plan_state_t        cur,
    output plan_state_t        nxt,
    output op_result_t         res
);

    // PAGE_BYTES is a power of two, so the page offset is a plain bit field.
    localparam int unsigned PAGE_W = $clog2(PAGE_BYTES);
    localparam int unsigned ROOM_W = PAGE_W + 1;
    localparam logic [CUR_W-1:0]  FLASH_END = CUR_W'(FLASH_BYTES);
    localparam logic [ROOM_W-1:0] PAGE_SIZE = ROOM_W'(PAGE_BYTES);

    logic [CUR_W-1:0]   end_sum;
    logic [CUR_W-1:0]   last_byte;
    logic               reject;
    logic               block_fits;
    logic [CUR_W-1:0]   erase_len;
    logic [CUR_W-1:0]   erase_next;
    logic [ROOM_W-1:0]  room;
    logic               fits_page;
    logic [ROOM_W-1:0]  chunk;

    always_comb begin
        end_sum   = CUR_W'(in_start_address) + CUR_W'(in_byte_count);
        last_byte = end_sum - CUR_W'(1);
        reject    = (in_byte_count == '0) || (CUR_W'(in_start_address) >= FLASH_END)
                    || (end_sum > FLASH_END);

        block_fits = (cur.erase_cursor[15:0] == 16'd0)
                     && ((cur.erase_cursor + BLOCK_TAIL) <= CUR_W'(cur.erase_limit));
        erase_len  = block_fits ? BLOCK_SPAN : SECTOR_SPAN;
        erase_next = cur.erase_cursor + erase_len;

        room      = PAGE_SIZE - ROOM_W'(cur.program_cursor[PAGE_W-1:0]);
        fits_page = cur.bytes_left <= COUNT_W'(room);
        chunk     = fits_page ? cur.bytes_left[ROOM_W-1:0] : room;
    end

    always_comb begin
        nxt = cur;
        res = '{kind: OP_NONE, address: '0, length: '0, error: 1'b0, last: 1'b0};
        if (in_command == CMD_START) begin
            if (reject) begin
                nxt.phase = PH_IDLE;
                res.error = 1'b1;
            end else begin
                nxt.phase          = PH_ERASE;
                nxt.erase_cursor   = CUR_W'(in_start_address) & ~CUR_W'(SECTOR_SPAN - 1'b1);
                nxt.erase_limit    = last_byte[LIMIT_W-1:0] & SECTOR_BASE;
                nxt.program_cursor = COUNT_W'(in_start_address);
                nxt.bytes_left     = in_byte_count;
                res.kind           = OP_ACCEPTED;
                res.address        = in_start_address;
            end
        end else begin
            unique case (cur.phase)
                PH_ERASE: begin
                    nxt.erase_cursor = erase_next;
                    if (erase_next > CUR_W'(cur.erase_limit)) begin
                        nxt.phase = PH_PROGRAM;
                    end
                    res.kind    = block_fits ? OP_ERASE_64K : OP_ERASE_4K;
                    res.address = cur.erase_cursor[ADDR_W-1:0];
                    res.length  = erase_len[LEN_W-1:0];
                end
                PH_PROGRAM: begin
                    nxt.program_cursor = cur.program_cursor + COUNT_W'(chunk);
                    nxt.bytes_left     = cur.bytes_left - COUNT_W'(chunk);
                    if (fits_page) begin
                        nxt.phase = PH_IDLE;
                    end
                    res.kind    = OP_PAGE_PROGRAM;
                    res.address = cur.program_cursor[ADDR_W-1:0];
                    res.length  = LEN_W'(chunk);
                    res.last    = fits_page;
                end
                default: begin
                    // Idle, or the unused phase code: nothing to hand out.
                end
            endcase
        end
    end

endmodule
